// ----- rtl/khss_pkg.sv -----
// khss_pkg: shared constants and types for the key hash server select block
// no dependencies; used by khss_mix, khss_div and key_hash_server_select
`timescale 1ns / 1ps

package khss_pkg;

  localparam int unsigned HASH_W  = 28;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned INDEX_W = 8;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd1;

  // start request from the sequencer to the divide unit
  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] dividend;
  } div_req_t;

endpackage

// ----- rtl/key_hash_server_select.sv -----
// key_hash_server_select: elf/pjw key hash reduced modulo a server count
// a byte that is not last is folded into the hash and the input stays ready; a last byte
// starts the remainder steps in khss_div, whose result passes the sequencer to the output
// no new item is taken while the remainder is being formed
// asynchronous active-low reset clears the hash, the sequencer and the output valid flag,
// and sets the server count to one
`timescale 1ns / 1ps

module key_hash_server_select #(
  parameter int unsigned MAX_SERVERS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,     // server_count
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] key_byte
  input  logic        s_axis_tlast_i,  // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // [7:0] server_index
  output logic [0:0]  m_axis_tuser_o   // [0] no_server
);

  localparam int unsigned DIV_W = $clog2(MAX_SERVERS + 1);
  localparam int unsigned CMP_W = (DIV_W > khss_pkg::COUNT_W) ? DIV_W : khss_pkg::COUNT_W;
  localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_SERVERS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [khss_pkg::COUNT_W-1:0] count_q;
  logic                         in_fire;
  logic                         out_free;
  logic [khss_pkg::HASH_W-1:0]  hash_next;
  khss_pkg::div_req_t           div_req;
  logic                         div_done;
  logic [DIV_W-1:0]             div_rem;
  logic [CMP_W-1:0]             count_ext;
  logic [CMP_W-1:0]             count_eff;
  logic [CMP_W-1:0]             rem_ext;
  logic                         ovalid_q, ovalid_d;
  logic [7:0]                   odata_q, odata_d;
  logic                         ouser_q, ouser_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= khss_pkg::COUNT_RESET;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // count above the maximum saturates
  always_comb begin
    count_ext = CMP_W'(count_q);
    count_eff = (count_ext > MAX_C) ? MAX_C : count_ext;
    rem_ext   = CMP_W'(div_rem);
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !ovalid_q || m_axis_tready_i;

  khss_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (in_fire),
    .last_i      (s_axis_tlast_i),
    .byte_i      (s_axis_tdata_i),
    .hash_next_o (hash_next)
  );

  assign div_req.start    = in_fire && s_axis_tlast_i;
  assign div_req.dividend = hash_next;

  khss_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .divisor_i (DIV_W'(count_eff)),
    .done_o    (div_done),
    .rem_o     (div_rem)
  );

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q;
    odata_d  = odata_q;
    ouser_d  = ouser_q;
    if (ovalid_q && m_axis_tready_i) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (div_req.start) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // remainder holds in the divide unit until the output slot frees up
        if (out_free) begin
          ovalid_d = 1'b1;
          ouser_d  = (count_eff == '0);
          odata_d  = (count_eff == '0) ? 8'd0 : rem_ext[7:0];
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
    ouser_q <= ouser_d;
  end

  assign m_axis_tvalid_o   = ovalid_q;
  assign m_axis_tdata_o    = odata_q;
  assign m_axis_tuser_o[0] = ouser_q;

endmodule

// ----- rtl/khss_mix.sv -----
// khss_mix: running elf/pjw hash register, one key byte folded in per item
// depends on khss_pkg
`timescale 1ns / 1ps

module khss_mix (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         last_i,
  input  logic [khss_pkg::BYTE_W-1:0]  byte_i,
  output logic [khss_pkg::HASH_W-1:0]  hash_next_o
);

  logic [khss_pkg::HASH_W-1:0] hash_q, hash_d;
  logic [31:0]                 sum;
  logic [3:0]                  top;

  always_comb begin
    sum = {hash_q, 4'b0000} + {24'd0, byte_i};
    top = sum[31:28];
    // top nibble folds back 24 bits lower, then is dropped
    hash_next_o = sum[27:0] ^ {20'd0, top, 4'b0000};
  end

  always_comb begin
    hash_d = hash_q;
    if (en_i) begin
      hash_d = last_i ? '0 : hash_next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
    end else begin
      hash_q <= hash_d;
    end
  end

endmodule

// ----- rtl/khss_div.sv -----
// khss_div: restoring remainder unit, one shared compare and subtract per cycle
// depends on khss_pkg; one dividend bit shifted in per step over the hash width
`timescale 1ns / 1ps

module khss_div #(
  parameter int unsigned DIV_W = 9
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  khss_pkg::div_req_t      req_i,
  input  logic [DIV_W-1:0]        divisor_i,
  output logic                    done_o,
  output logic [DIV_W-1:0]        rem_o
);

  localparam int unsigned CNT_W = $clog2(khss_pkg::HASH_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(khss_pkg::HASH_W - 1);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [khss_pkg::HASH_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0]            rem_q, rem_d;
  logic [DIV_W-1:0]            dvs_q, dvs_d;
  logic [DIV_W:0]              shifted;
  logic [DIV_W:0]              diff;
  logic                        fits;

  always_comb begin
    shifted = {rem_q, quo_q[khss_pkg::HASH_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    fits    = shifted >= {1'b0, dvs_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo_d = {quo_q[khss_pkg::HASH_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ----- rtl/khss_checker.sv -----
// khss_checker: port-level assertions for key_hash_server_select
// depends on key_hash_server_select ports only; bound to the top level below
`timescale 1ns / 1ps

module khss_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       s_axis_tlast_i,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic [0:0] m_axis_tuser_o
);

  // a stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result item changed");

  // no server means index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o == 8'd0)
    else $error("no_server with nonzero index");

  // last byte starts the remainder, input closes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input open during remainder");

  // a new result only appears out of the busy phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result item without preceding divide");

endmodule

bind key_hash_server_select khss_checker u_khss_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
